[hdl/itp_pkg.sv]
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [2:0] CODE_PAREN = 3'd1;
    localparam logic [2:0] CODE_ADD   = 3'd2;
    localparam logic [2:0] CODE_SUB   = 3'd3;
    localparam logic [2:0] CODE_MUL   = 3'd4;
    localparam logic [2:0] CODE_DIV   = 3'd5;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CLOSE    = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_OPEN     = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } char_class_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_PAREN,
        PUSH_OP
    } push_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LETTER,
        EMIT_OP,
        EMIT_STATUS
    } emit_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLOSE_RD,
        S_CLOSE_CHK,
        S_OP_RD,
        S_OP_CHK,
        S_OP_PUSH,
        S_TAIL,
        S_FLUSH_RD,
        S_FLUSH_CHK,
        S_STATUS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      load;
        logic      rd;
        logic      pop;
        push_sel_t push;
        emit_sel_t emit;
        err_t      raise;
        logic      clear_expr;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        char_class_t cls;
        logic        last;
        logic        empty;
        logic        top_paren;
        logic        top_lower;
        logic        emit_ok;
        logic        pend_valid;
        logic        out_free;
    } dp_stat_t;

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_PAREN: c = CH_OPEN;
            CODE_ADD:   c = CH_ADD;
            CODE_SUB:   c = CH_SUB;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_ADD:  code = CODE_ADD;
            CH_SUB:  code = CODE_SUB;
            CH_MUL:  code = CODE_MUL;
            CH_DIV:  code = CODE_DIV;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    function automatic logic prec_high(input logic [2:0] code);
        return code >= CODE_MUL;
    endfunction

endpackage

`default_nettype wire

[hdl/itp_ctrl.sv]
`default_nettype none

module itp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire itp_pkg::dp_stat_t stat,
    output itp_pkg::ctrl_cmd_t     cmd
);
    import itp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cls)
                    CLS_ALNUM:
                    begin
                        if (stat.emit_ok)
                        begin
                            cmd.emit   = EMIT_LETTER;
                            state_next = S_TAIL;
                        end
                    end
                    CLS_OPEN:
                    begin
                        cmd.push   = PUSH_PAREN;
                        state_next = S_TAIL;
                    end
                    CLS_CLOSE: state_next = S_CLOSE_RD;
                    CLS_OP:    state_next = S_OP_RD;
                    default:   state_next = S_TAIL;
                endcase
            end
            S_CLOSE_RD:
            begin
                if (stat.empty)
                begin
                    cmd.raise  = ERR_CLOSE;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CLOSE_CHK;
                end
            end
            S_CLOSE_CHK:
            begin
                if (stat.top_paren)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_TAIL;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit   = EMIT_OP;
                    cmd.pop    = 1'b1;
                    state_next = S_CLOSE_RD;
                end
            end
            S_OP_RD:
            begin
                if (stat.empty)
                begin
                    state_next = S_OP_PUSH;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_OP_CHK;
                end
            end
            S_OP_CHK:
            begin
                if (stat.top_lower)
                begin
                    state_next = S_OP_PUSH;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit   = EMIT_OP;
                    cmd.pop    = 1'b1;
                    state_next = S_OP_RD;
                end
            end
            S_OP_PUSH:
            begin
                cmd.push   = PUSH_OP;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                state_next = stat.last ? S_FLUSH_RD : S_DONE;
            end
            S_FLUSH_RD:
            begin
                if (stat.empty)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_FLUSH_CHK;
                end
            end
            S_FLUSH_CHK:
            begin
                if (stat.top_paren)
                begin
                    cmd.raise  = ERR_OPEN;
                    cmd.pop    = 1'b1;
                    state_next = S_FLUSH_RD;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit   = EMIT_OP;
                    cmd.pop    = 1'b1;
                    state_next = S_FLUSH_RD;
                end
            end
            S_STATUS:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit       = EMIT_STATUS;
                    cmd.clear_expr = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    ast_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE && in_valid)
        else $error("load outside idle");
    ast_status_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_expr |=> state_reg == S_DONE)
        else $error("status not followed by done");
    ast_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop from empty stack");
`endif

endmodule

`default_nettype wire

[hdl/itp_dpath.sv]
`default_nettype none

module itp_dpath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         ch,
    input  wire logic               last,
    input  wire itp_pkg::ctrl_cmd_t cmd,
    output itp_pkg::dp_stat_t       stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    has_char,
    output logic [7:0]              out_char,
    output logic                    run_end,
    output logic                    expr_end,
    output logic [1:0]              status
);
    import itp_pkg::*;

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]    mem [STACK_DEPTH];
    logic [2:0]    top_reg;
    logic [7:0]    ch_reg;
    logic          last_reg;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_dec;
    err_t          err_reg, err_next;
    logic          full;
    logic [2:0]    push_code;
    logic          push_wr;
    err_t          raise_eff;

    logic          pend_valid_reg, pend_valid_next;
    logic          pend_has_reg, pend_has_next;
    logic [7:0]    pend_char_reg, pend_char_next;
    logic          pend_xend_reg, pend_xend_next;
    logic [1:0]    pend_st_reg, pend_st_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_has_reg, out_has_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_run_reg, out_run_next;
    logic          out_xend_reg, out_xend_next;
    logic [1:0]    out_st_reg, out_st_next;

    logic          out_free;
    logic [2:0]    in_code;

    assign cnt_dec  = cnt_reg - CW'(1);
    assign full     = cnt_reg == CW'(STACK_DEPTH);
    assign out_free = !out_valid_reg || out_ready;
    assign in_code  = op_code(ch_reg);

    always_comb begin
        if ((ch_reg inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]})) begin
            stat.cls = CLS_ALNUM;
        end
        else if (ch_reg == CH_OPEN) begin
            stat.cls = CLS_OPEN;
        end
        else if (ch_reg == CH_CLOSE) begin
            stat.cls = CLS_CLOSE;
        end
        else if (in_code != 3'd0) begin
            stat.cls = CLS_OP;
        end
        else begin
            stat.cls = CLS_OTHER;
        end
        stat.last       = last_reg;
        stat.empty      = cnt_reg == '0;
        stat.top_paren  = top_reg == CODE_PAREN;
        stat.top_lower  = top_reg < CODE_ADD || (!prec_high(top_reg) && prec_high(in_code));
        stat.emit_ok    = !pend_valid_reg || out_free;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    // stack
    always_comb begin
        push_code = (cmd.push == PUSH_PAREN) ? CODE_PAREN : in_code;
        push_wr   = (cmd.push != PUSH_NONE) && !full;
        raise_eff = cmd.raise;
        if (cmd.push != PUSH_NONE && full) begin
            raise_eff = ERR_OVERFLOW;
        end

        cnt_next = cnt_reg;
        if (cmd.clear_expr) begin
            cnt_next = '0;
        end
        else if (cmd.pop) begin
            cnt_next = cnt_dec;
        end
        else if (push_wr) begin
            cnt_next = cnt_reg + CW'(1);
        end

        err_next = err_reg;
        if (cmd.clear_expr) begin
            err_next = ERR_NONE;
        end
        else if (err_reg == ERR_NONE) begin
            err_next = raise_eff;
        end
    end

    always_ff @(posedge clk) begin
        if (push_wr) begin
            mem[cnt_reg[IW-1:0]] <= push_code;
        end
        if (cmd.rd) begin
            top_reg <= mem[cnt_dec[IW-1:0]];
        end
        if (cmd.load) begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    // result staging: pending word waits until it is known whether it ends the run
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_has_next   = pend_has_reg;
        pend_char_next  = pend_char_reg;
        pend_xend_next  = pend_xend_reg;
        pend_st_next    = pend_st_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_has_next    = out_has_reg;
        out_char_next   = out_char_reg;
        out_run_next    = out_run_reg;
        out_xend_next   = out_xend_reg;
        out_st_next     = out_st_reg;

        if ((cmd.emit != EMIT_NONE && pend_valid_reg) || cmd.finish) begin
            out_valid_next = 1'b1;
            out_has_next   = pend_has_reg;
            out_char_next  = pend_char_reg;
            out_run_next   = cmd.finish;
            out_xend_next  = pend_xend_reg;
            out_st_next    = pend_st_reg;
        end

        if (cmd.finish) begin
            pend_valid_next = 1'b0;
        end

        case (cmd.emit)
            EMIT_LETTER: begin
                pend_valid_next = 1'b1;
                pend_has_next   = 1'b1;
                pend_char_next  = ch_reg;
                pend_xend_next  = 1'b0;
                pend_st_next    = ERR_NONE;
            end
            EMIT_OP: begin
                pend_valid_next = 1'b1;
                pend_has_next   = 1'b1;
                pend_char_next  = code_char(top_reg);
                pend_xend_next  = 1'b0;
                pend_st_next    = ERR_NONE;
            end
            EMIT_STATUS: begin
                pend_valid_next = 1'b1;
                pend_has_next   = 1'b0;
                pend_char_next  = 8'h00;
                pend_xend_next  = 1'b1;
                pend_st_next    = err_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg        <= '0;
            err_reg        <= ERR_NONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        pend_has_reg  <= pend_has_next;
        pend_char_reg <= pend_char_next;
        pend_xend_reg <= pend_xend_next;
        pend_st_reg   <= pend_st_next;
        out_has_reg   <= out_has_next;
        out_char_reg  <= out_char_next;
        out_run_reg   <= out_run_next;
        out_xend_reg  <= out_xend_next;
        out_st_reg    <= out_st_next;
    end

    assign out_valid = out_valid_reg;
    assign has_char  = out_has_reg;
    assign out_char  = out_char_reg;
    assign run_end   = out_run_reg;
    assign expr_end  = out_xend_reg;
    assign status    = out_st_reg;

`ifndef SYNTHESIS
    ast_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    ast_expr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_expr |=> cnt_reg == '0 && err_reg == ERR_NONE)
        else $error("expression state not cleared");
    ast_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg && out_run_reg && !pend_valid_reg)
        else $error("run end word not presented");
    ast_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EMIT_NONE || cmd.finish) && pend_valid_reg |-> out_free)
        else $error("pending word overwritten");
`endif

endmodule

`default_nettype wire

[hdl/infix_to_postfix_converter.sv]
// Steps: a letter or digit is staged as a pending word at dispatch; each stack pop takes
// a read state, then a check/emit state; an expression end flushes every entry that way,
// then emits a status word. Throughput: one word at a time; the next is taken only once
// the stack walk for an operator or ')' and any operator push are done.
// Output stalls hold the emit steps and the run-end word.
// Reset: asynchronous, active low; clears stack count, error code and valid flags.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            has_char,
    output logic [7:0]      out_char,
    output logic            run_end,
    output logic            expr_end,
    output logic [1:0]      status
);
    import itp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_char  (has_char),
        .out_char  (out_char),
        .run_end   (run_end),
        .expr_end  (expr_end),
        .status    (status)
    );

endmodule

`default_nettype wire

[verif/tb_infix_to_postfix_converter.sv]
`default_nettype none

module tb_infix_to_postfix_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int N_ITEMS      = 270;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       run_end;
        logic       expr_end;
        err_t       status;
    } pf_word_t;

    typedef struct packed {
        logic [7:0] c;
        logic       l;
        logic       typed;
        pf_word_t   want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] ch;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic       has_char;
    logic [7:0] out_char;
    logic       run_end;
    logic       expr_end;
    logic [1:0] status;

    infix_to_postfix_converter #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ch       (ch),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .has_char (has_char),
        .out_char (out_char),
        .run_end  (run_end),
        .expr_end (expr_end),
        .status   (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [2:0] opstk [DEPTH];
    int         opcnt;
    err_t       sticky;
    pf_word_t   held;
    bit         held_ok;
    pf_word_t   postfix_q [$];
    pf_word_t   due;

    int  mismatches;
    int  checked;
    int  words_sent;
    int  exprs;
    int  max_depth;
    int  st_seen [4];
    int  cycle_cnt;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  hold_req;
    bit  hold_done;

    // directed words; typed rows carry their result, the rest go through the predictor
    stim_row_t dir_tab [25] = '{
        '{"A",   1'b0, 1'b1, '{1'b1, "A",   1'b1, 1'b0, ERR_NONE}},
        '{"z",   1'b0, 1'b1, '{1'b1, "z",   1'b1, 1'b0, ERR_NONE}},
        '{"0",   1'b0, 1'b1, '{1'b1, "0",   1'b1, 1'b0, ERR_NONE}},
        '{"9",   1'b0, 1'b1, '{1'b1, "9",   1'b1, 1'b0, ERR_NONE}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{")",   1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, ERR_CLOSE}},
        '{"(",   1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, ERR_OPEN}},
        '{"a",   1'b0, 1'b0, '0},
        '{"+",   1'b0, 1'b0, '0},
        '{"b",   1'b0, 1'b0, '0},
        '{"*",   1'b0, 1'b0, '0},
        '{"(",   1'b0, 1'b0, '0},
        '{"c",   1'b0, 1'b0, '0},
        '{"-",   1'b0, 1'b0, '0},
        '{"d",   1'b0, 1'b0, '0},
        '{")",   1'b0, 1'b0, '0},
        '{"/",   1'b0, 1'b0, '0},
        '{"e",   1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{"-",   1'b0, 1'b0, '0},
        '{"b",   1'b0, 1'b0, '0},
        '{")",   1'b0, 1'b0, '0},
        '{"+",   1'b1, 1'b0, '0}
    };

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [2:0] op_of(logic [7:0] c);
        case (c)
            CH_ADD:  return CODE_ADD;
            CH_SUB:  return CODE_SUB;
            CH_MUL:  return CODE_MUL;
            CH_DIV:  return CODE_DIV;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] sym_of(logic [2:0] code);
        case (code)
            CODE_ADD: return CH_ADD;
            CODE_SUB: return CH_SUB;
            CODE_MUL: return CH_MUL;
            CODE_DIV: return CH_DIV;
            default:  return 8'h00;
        endcase
    endfunction

    // one-word delay so the final word of a step can get run_end
    function automatic void stage_word(pf_word_t w);
        if (held_ok)
            postfix_q.push_back(held);
        held    = w;
        held_ok = 1'b1;
    endfunction

    function automatic void stage_char(logic [7:0] c);
        stage_word('{1'b1, c, 1'b0, 1'b0, ERR_NONE});
    endfunction

    function automatic void flag_err(err_t e);
        if (sticky == ERR_NONE)
            sticky = e;
    endfunction

    function automatic void push_code(logic [2:0] code);
        if (opcnt >= DEPTH)
        begin
            flag_err(ERR_OVERFLOW);
        end
        else
        begin
            opstk[opcnt] = code;
            opcnt++;
            if (opcnt > max_depth)
                max_depth = opcnt;
        end
    endfunction

    function automatic void convert_char(logic [7:0] c, logic l);
        logic [2:0] code;
        logic [2:0] top;
        bit         found;
        held_ok = 1'b0;
        code    = op_of(c);
        if (is_alnum(c))
        begin
            stage_char(c);
        end
        else if (c == CH_OPEN)
        begin
            push_code(CODE_PAREN);
        end
        else if (c == CH_CLOSE)
        begin
            found = 1'b0;
            while (opcnt > 0 && !found)
            begin
                top = opstk[opcnt-1];
                opcnt--;
                if (top == CODE_PAREN)
                    found = 1'b1;
                else
                    stage_char(sym_of(top));
            end
            if (!found)
                flag_err(ERR_CLOSE);
        end
        else if (code != 3'd0)
        begin
            while (opcnt > 0 && opstk[opcnt-1] != CODE_PAREN &&
                   (opstk[opcnt-1] >= CODE_MUL || code < CODE_MUL))
            begin
                opcnt--;
                stage_char(sym_of(opstk[opcnt]));
            end
            push_code(code);
        end
        if (l)
        begin
            while (opcnt > 0)
            begin
                top = opstk[opcnt-1];
                opcnt--;
                if (top == CODE_PAREN)
                    flag_err(ERR_OPEN);
                else
                    stage_char(sym_of(top));
            end
            stage_word('{1'b0, 8'h00, 1'b0, 1'b1, sticky});
            st_seen[sticky]++;
            opcnt  = 0;
            sticky = ERR_NONE;
        end
        if (held_ok)
        begin
            held.run_end = 1'b1;
            postfix_q.push_back(held);
        end
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %02h want %02h (word %0d)", name, got, want, checked));
    endtask

    task automatic send_word(logic [7:0] c, logic l, logic typed = 1'b0, pf_word_t want = '0);
        int qn;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        qn = postfix_q.size();
        convert_char(c, l);
        if (typed)
        begin
            while (postfix_q.size() > qn)
                void'(postfix_q.pop_back());
            postfix_q.push_back(want);
        end
        words_sent++;
    endtask

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(0, 2))
            0:       return 8'(int'("A") + $urandom_range(0, 25));
            1:       return 8'(int'("a") + $urandom_range(0, 25));
            default: return 8'(int'("0") + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    task automatic run_expr(int open_pct, bit broken);
        logic [7:0] txt [$];
        int depth;
        int len;
        int k;
        int pos;
        depth = 0;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        for (k = 0; k < len; k++)
        begin
            while ($urandom_range(0, 99) < open_pct)
            begin
                txt.push_back(CH_OPEN);
                depth++;
            end
            txt.push_back(rand_operand());
            if ($urandom_range(0, 9) == 0)
                txt.push_back(8'h20);
            while (depth > 0 && $urandom_range(0, 99) < 40)
            begin
                txt.push_back(CH_CLOSE);
                depth--;
            end
            if (k < len - 1)
                txt.push_back(rand_op());
        end
        while (depth > 0)
        begin
            txt.push_back(CH_CLOSE);
            depth--;
        end
        if (broken)
        begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0:       txt.insert(pos, CH_OPEN);
                1:       txt.insert(pos, CH_CLOSE);
                default: txt.delete(pos);
            endcase
            if (txt.size() == 0)
                txt.push_back(rand_op());
        end
        if ($urandom_range(0, 7) == 0)
            txt.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < txt.size(); k++)
            send_word(txt[k], k == txt.size() - 1);
        exprs++;
    endtask

    task automatic run_noise();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_word(8'($urandom_range(0, 255)), k == n - 1);
        exprs++;
    endtask

    // output side: short random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (postfix_q.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word has_char=%0b out_char=%02h status=%0d",
                                        has_char, out_char, status));
            end
            else
            begin
                due = postfix_q.pop_front();
                check_field("has_char", has_char, due.has_char);
                check_field("out_char", out_char, due.out_char);
                check_field("run_end", run_end, due.run_end);
                check_field("expr_end", expr_end, due.expr_end);
                check_field("status", status, due.status);
                checked++;
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d words still due", cycle_cnt, postfix_q.size());
        $display("tb_infix_to_postfix_converter: FAIL");
        $finish;
    end

    initial
    begin
        int k;
        int pick;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        ch         = 8'h00;
        last       = 1'b0;
        tx_gaps    = 1'b1;
        rx_gaps    = 1'b1;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        opcnt      = 0;
        sticky     = ERR_NONE;
        held_ok    = 1'b0;
        mismatches = 0;
        checked    = 0;
        words_sent = 0;
        exprs      = 0;
        max_depth  = 0;
        foreach (st_seen[i])
            st_seen[i] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_word(dir_tab[i].c, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].want);

        // fill the stack past its depth, then an operator onto the full stack
        for (k = 0; k < DEPTH + 1; k++)
            send_word(CH_OPEN, 1'b0);
        send_word(CH_ADD, 1'b0);
        send_word("7", 1'b1);

        while (words_sent < N_ITEMS)
        begin
            if (!hold_done && words_sent >= 120)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (words_sent >= N_ITEMS - 40)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                run_expr(60, 1'b0);
            else if (pick < 70)
                run_expr(15, 1'b0);
            else if (pick < 85)
                run_expr(20, 1'b1);
            else
                run_noise();
        end
        in_valid <= 1'b0;

        while (postfix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words in %0d expressions sent, %0d postfix words checked, deepest stack %0d",
                 words_sent, exprs, checked, max_depth);
        $display("status words: ok %0d, unmatched close %0d, overflow %0d, unmatched open %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
        if (mismatches == 0)
        begin
            $display("tb_infix_to_postfix_converter: PASS");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("tb_infix_to_postfix_converter: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
